FILE: src/assert_macros.svh
// Assertion macros used by the controller of the two-band QMF synthesis block.
// Each macro checks a property on the rising edge of clk_i outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is never true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/qmf_pkg.sv
// Package for the two-band QMF synthesis block: widths, tap tables and the
// command struct that joins the controller to the datapath. No dependencies.
`default_nettype none

package qmf_pkg;

  localparam int SAMPLE_W       = 15;
  localparam int TAP_W          = 13;
  localparam int TAPS_PER_PHASE = 12;
  localparam int PROD_W         = SAMPLE_W + TAP_W;
  localparam int ACC_W          = PROD_W + 1;
  localparam int OUT_SHIFT      = 12;
  localparam int IDX_W          = $clog2(TAPS_PER_PHASE);
  localparam int CNT_W          = $clog2(TAPS_PER_PHASE + 1);

  localparam logic signed [TAP_W-1:0] EVEN_TAPS [TAPS_PER_PHASE] = '{
    13'sd3, -13'sd11, 13'sd12, 13'sd32, -13'sd210, 13'sd951,
    13'sd3876, -13'sd805, 13'sd362, -13'sd156, 13'sd53, -13'sd11
  };

  localparam logic signed [TAP_W-1:0] ODD_TAPS [TAPS_PER_PHASE] = '{
    -13'sd11, 13'sd53, -13'sd156, 13'sd362, -13'sd805, 13'sd3876,
    13'sd951, -13'sd210, 13'sd32, 13'sd12, -13'sd11, 13'sd3
  };

  typedef struct packed {
    logic             load;       // shift a new item into both delay lines
    logic             mul_en;     // register one product
    logic             acc_en;     // add the registered product
    logic             acc_first;  // first product of a phase replaces the sum
    logic [IDX_W-1:0] idx;        // tap index of the product
    logic             phase;      // 0: difference line, 1: sum line
    logic             out_load;   // capture the finished sample for output
  } qmf_cmd_t;

endpackage

`default_nettype wire

FILE: src/qmf_datapath.sv
// Datapath of the two-band QMF synthesis block: delay lines, one shared
// multiplier, the accumulator and the output register. Uses qmf_pkg.
`default_nettype none

module qmf_datapath import qmf_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire qmf_cmd_t                   cmd_i,
  input  wire logic signed [SAMPLE_W-1:0] low_band_sample_i,
  input  wire logic signed [SAMPLE_W-1:0] high_band_sample_i,
  output logic signed [SAMPLE_W-1:0]      pcm_sample_o,
  output logic                            last_of_pair_o
);

  localparam int SHIFTED_W = ACC_W - OUT_SHIFT;

  logic signed [SAMPLE_W-1:0] diff_q [TAPS_PER_PHASE];
  logic signed [SAMPLE_W-1:0] sum_q  [TAPS_PER_PHASE];
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [SAMPLE_W-1:0] pcm_q;
  logic                       last_q;

  logic signed [SAMPLE_W:0]    diff_wide, sum_wide;
  logic signed [SAMPLE_W-1:0]  diff_sat, sum_sat;
  logic signed [SAMPLE_W-1:0]  line_sel;
  logic signed [TAP_W-1:0]     tap_sel;
  logic signed [SHIFTED_W-1:0] shifted;
  logic signed [SAMPLE_W-1:0]  pcm_d;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Sum and difference are one bit wider; overflow shows as the top two bits differing.
  always_comb begin
    diff_wide = {low_band_sample_i[SAMPLE_W-1], low_band_sample_i}
              - {high_band_sample_i[SAMPLE_W-1], high_band_sample_i};
    sum_wide  = {low_band_sample_i[SAMPLE_W-1], low_band_sample_i}
              + {high_band_sample_i[SAMPLE_W-1], high_band_sample_i};
    if (diff_wide[SAMPLE_W] != diff_wide[SAMPLE_W-1]) begin
      diff_sat = diff_wide[SAMPLE_W] ? SAT_MIN : SAT_MAX;
    end else begin
      diff_sat = diff_wide[SAMPLE_W-1:0];
    end
    if (sum_wide[SAMPLE_W] != sum_wide[SAMPLE_W-1]) begin
      sum_sat = sum_wide[SAMPLE_W] ? SAT_MIN : SAT_MAX;
    end else begin
      sum_sat = sum_wide[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS_PER_PHASE; i++) begin
        diff_q[i] <= '0;
        sum_q[i]  <= '0;
      end
    end else if (cmd_i.load) begin
      diff_q[0] <= diff_sat;
      sum_q[0]  <= sum_sat;
      for (int i = 1; i < TAPS_PER_PHASE; i++) begin
        diff_q[i] <= diff_q[i-1];
        sum_q[i]  <= sum_q[i-1];
      end
    end
  end

  always_comb begin
    line_sel = cmd_i.phase ? sum_q[cmd_i.idx] : diff_q[cmd_i.idx];
    tap_sel  = cmd_i.phase ? ODD_TAPS[cmd_i.idx] : EVEN_TAPS[cmd_i.idx];
    // Both operands are sign-extended first so the full product is kept.
    prod_d   = PROD_W'(line_sel) * PROD_W'(tap_sel);
    if (cmd_i.acc_first) begin
      acc_d = ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  // Arithmetic shift rounds toward minus infinity, then clamp to the sample range.
  always_comb begin
    shifted = acc_q[ACC_W-1:OUT_SHIFT];
    if (shifted > SHIFTED_W'(SAT_MAX)) begin
      pcm_d = SAT_MAX;
    end else if (shifted < SHIFTED_W'(SAT_MIN)) begin
      pcm_d = SAT_MIN;
    end else begin
      pcm_d = shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pcm_q  <= pcm_d;
      last_q <= cmd_i.phase;
    end
  end

  assign pcm_sample_o   = pcm_q;
  assign last_of_pair_o = last_q;

endmodule

`default_nettype wire

FILE: src/qmf_ctrl.sv
// Controller of the two-band QMF synthesis block: sequences the two filter
// phases and owns both handshakes. Uses qmf_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module qmf_ctrl import qmf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output qmf_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_RESULT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             phase_q, phase_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  qmf_cmd_t         cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = '0;
    cmd.phase   = phase_q;
    cmd.idx     = cnt_q[IDX_W-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          cnt_d    = '0;
          phase_d  = 1'b0;
          state_d  = ST_MAC;
        end
      end
      ST_MAC: begin
        // Products lead the accumulator through the product register.
        cmd.mul_en    = (cnt_q != CNT_W'(TAPS_PER_PHASE));
        cmd.acc_en    = (cnt_q != '0);
        cmd.acc_first = (cnt_q == CNT_W'(1));
        cnt_d         = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(TAPS_PER_PHASE)) begin
          cnt_d   = cnt_q;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          if (!phase_q) begin
            phase_d = 1'b1;
            cnt_d   = '0;
            state_d = ST_MAC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `ASSERT_PROP(a_accept_starts_even, (in_valid_i && in_ready_o) |=> (state_q == ST_MAC && !phase_q && cnt_q == '0), "accepted item did not start the even phase")
  `ASSERT_PROP(a_no_overwrite, cmd.out_load |-> (!out_valid_q || out_ready_i), "output register overwritten while a sample waits")
  `ASSERT_PROP(a_mul_in_range, cmd.mul_en |-> (cnt_q < CNT_W'(TAPS_PER_PHASE)), "tap index out of range")
  `ASSERT_PROP(a_odd_after_even, (cmd.out_load && !phase_q) |=> (state_q == ST_MAC && phase_q && cnt_q == '0), "odd phase did not follow the even result")

endmodule

`default_nettype wire

FILE: src/qmf_synthesis_two_band.sv
// Two-band QMF synthesis filter (24-tap receive QMF): each item is a pair of
// low-band and high-band samples and yields two 15-bit PCM samples, the even
// phase first and then the odd phase, flagged by last_of_pair_o. One shared
// 15x13 multiplier with a registered product and accumulator works through the
// 12 taps of each phase: an item is accepted in the idle state, then each
// phase runs a multiply-accumulate pass and a result step that waits for a
// free output register. A new item is taken while the odd sample still
// waits in the output register. Both delay lines clear on reset. Uses qmf_pkg.
`default_nettype none

module qmf_synthesis_two_band import qmf_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] low_band_sample_i,
  input  wire logic signed [SAMPLE_W-1:0] high_band_sample_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0]      pcm_sample_o,
  output logic                            last_of_pair_o
);

  qmf_cmd_t cmd;

  qmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  qmf_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .low_band_sample_i  (low_band_sample_i),
    .high_band_sample_i (high_band_sample_i),
    .pcm_sample_o       (pcm_sample_o),
    .last_of_pair_o     (last_of_pair_o)
  );

endmodule

`default_nettype wire

FILE: tb/qmf_output_checker.sv
// Checker for the two-band QMF synthesis block: it watches both channels,
// predicts the two PCM samples of every accepted item and compares them in order.
// Depends on qmf_pkg for the sample width and the tap count.
`timescale 1ns / 1ps

module qmf_output_checker import qmf_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic signed [SAMPLE_W-1:0] low_band_sample_i,
  input  wire logic signed [SAMPLE_W-1:0] high_band_sample_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic signed [SAMPLE_W-1:0] pcm_sample_i,
  input  wire logic                       last_of_pair_i,
  output int                              error_count_o,
  output int                              pending_o
);

  localparam longint PCM_MAX = 16383;
  localparam longint PCM_MIN = -16384;
  localparam int SCALE_SHIFT = 12;
  localparam int MAX_PRINTED = 200;

  localparam int EVEN_COEF [TAPS_PER_PHASE] = '{
    3, -11, 12, 32, -210, 951, 3876, -805, 362, -156, 53, -11
  };
  localparam int ODD_COEF [TAPS_PER_PHASE] = '{
    -11, 53, -156, 362, -805, 3876, 951, -210, 32, 12, -11, 3
  };

  typedef struct {
    logic signed [SAMPLE_W-1:0] pcm;
    logic                       is_odd;
  } pcm_item_t;

  // Newest sample sits at entry 0 of each line.
  logic signed [SAMPLE_W-1:0] diff_line [TAPS_PER_PHASE];
  logic signed [SAMPLE_W-1:0] sum_line  [TAPS_PER_PHASE];
  pcm_item_t                  pcm_expected [$];
  int                         errors;

  function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint v);
    if (v > PCM_MAX) return PCM_MAX[SAMPLE_W-1:0];
    if (v < PCM_MIN) return PCM_MIN[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

  // The arithmetic shift of a signed sum rounds toward minus infinity.
  function automatic logic signed [SAMPLE_W-1:0] phase_output(input bit odd_phase);
    longint acc;
    int     k;
    acc = 0;
    for (k = 0; k < TAPS_PER_PHASE; k++) begin
      if (odd_phase) acc += longint'(sum_line[k]) * longint'(ODD_COEF[k]);
      else acc += longint'(diff_line[k]) * longint'(EVEN_COEF[k]);
    end
    return clamp_sample(acc >>> SCALE_SHIFT);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("%0t ns: pcm mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pcm_item_t want;
    int        k;
    if (!rst_ni) begin
      for (k = 0; k < TAPS_PER_PHASE; k++) begin
        diff_line[k] = '0;
        sum_line[k]  = '0;
      end
      pcm_expected.delete();
      errors = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pcm_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected item pcm=%0d last=%0b",
                                    pcm_sample_i, last_of_pair_i));
        end else begin
          want = pcm_expected.pop_front();
          if (pcm_sample_i !== want.pcm)
            report_mismatch($sformatf("pcm_sample got %0d, want %0d",
                                      pcm_sample_i, want.pcm));
          if (last_of_pair_i !== want.is_odd)
            report_mismatch($sformatf("last_of_pair got %0b, want %0b",
                                      last_of_pair_i, want.is_odd));
        end
      end
      if (in_valid_i && in_ready_i) begin
        for (k = TAPS_PER_PHASE - 1; k > 0; k--) begin
          diff_line[k] = diff_line[k-1];
          sum_line[k]  = sum_line[k-1];
        end
        diff_line[0] = clamp_sample(longint'(low_band_sample_i) -
                                    longint'(high_band_sample_i));
        sum_line[0]  = clamp_sample(longint'(low_band_sample_i) +
                                    longint'(high_band_sample_i));
        pcm_expected.push_back('{pcm: phase_output(1'b0), is_odd: 1'b0});
        pcm_expected.push_back('{pcm: phase_output(1'b1), is_odd: 1'b1});
      end
      error_count_o <= errors;
      pending_o     <= pcm_expected.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the testbench for qmf_synthesis_two_band: clock, reset, stimulus and
// output back-pressure, with qmf_output_checker beside the block for checking.
// Depends on qmf_pkg, the block and the checker.
`timescale 1ns / 1ps

module testbench;
  import qmf_pkg::*;

  localparam int ITEMS_PER_PHASE = 440;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 100;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int NUM_PHASES      = 4;
  localparam int IDLE_PCT  [NUM_PHASES] = '{0, 75, 0, 8};
  localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 75, 8};

  localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 15'sh3FFF;
  localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 15'sh4000;

  // Bit i is set where tap i of the phase is positive.
  localparam bit [TAPS_PER_PHASE-1:0] EVEN_POSITIVE = 12'b0101_0110_1101;
  localparam bit [TAPS_PER_PHASE-1:0] ODD_POSITIVE  = 12'b1011_0110_1010;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] low_band;
  logic signed [SAMPLE_W-1:0] high_band;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] pcm_sample;
  logic                       last_of_pair;
  int                         error_count;
  int                         pending;

  int sender_idle_pct;
  int stall_pct;
  bit hold_toggle;
  int cycle_count;

  qmf_synthesis_two_band DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .low_band_sample_i  (low_band),
    .high_band_sample_i (high_band),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .pcm_sample_o       (pcm_sample),
    .last_of_pair_o     (last_of_pair)
  );

  qmf_output_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .low_band_sample_i  (low_band),
    .high_band_sample_i (high_band),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .pcm_sample_i       (pcm_sample),
    .last_of_pair_i     (last_of_pair),
    .error_count_o      (error_count),
    .pending_o          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Back-pressure: random stalls, plus a long hold-off whenever the stimulus
  // flips hold_toggle.
  initial begin
    bit hold_seen;
    int hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_toggle) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] raw;
    case ($urandom_range(7))
      0: raw = PCM_MAX;
      1: raw = PCM_MIN;
      2: raw = SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
      default: raw = SAMPLE_W'($urandom);
    endcase
    return raw;
  endfunction

  task automatic send_pair(input logic signed [SAMPLE_W-1:0] lo,
                           input logic signed [SAMPLE_W-1:0] hi);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    low_band  <= lo;
    high_band <= hi;
    do @(posedge clk); while (!in_ready);
  endtask

  // Always waits on the clock before it returns, so valid never drops and rises in one step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    int                         tap;
    int                         p;
    int                         n;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    low_band    <= '0;
    high_band   <= '0;
    cycle_count <= 0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_toggle     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corners: zero, sum and difference saturating both ways, all-ones words.
    send_pair('0, '0);
    send_pair(PCM_MAX, PCM_MAX);
    send_pair(PCM_MIN, PCM_MIN);
    send_pair(PCM_MAX, PCM_MIN);
    send_pair(PCM_MIN, PCM_MAX);
    send_pair(-15'sd1, -15'sd1);

    // Line up extreme samples against the tap signs so that the even phase
    // saturates high and the odd phase saturates low on the last item.
    for (n = 0; n < TAPS_PER_PHASE; n++) begin
      tap = TAPS_PER_PHASE - 1 - n;
      case ({EVEN_POSITIVE[tap], !ODD_POSITIVE[tap]})
        2'b11:   begin lo = PCM_MAX; hi = '0;      end
        2'b10:   begin lo = '0;      hi = PCM_MIN; end
        2'b01:   begin lo = '0;      hi = PCM_MAX; end
        default: begin lo = PCM_MIN; hi = '0;      end
      endcase
      send_pair(lo, hi);
    end
    wait_drained();

    for (p = 0; p < NUM_PHASES; p++) begin
      sender_idle_pct = IDLE_PCT[p];
      stall_pct       = STALL_PCT[p];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 0 && n == 60) hold_toggle = ~hold_toggle;
        if (p == 2 && n == 200) wait_drained();
        send_pair(pick_sample(), pick_sample());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: qmf_synthesis_two_band.f
+incdir+src
src/qmf_pkg.sv
src/qmf_datapath.sv
src/qmf_ctrl.sv
src/qmf_synthesis_two_band.sv
tb/qmf_output_checker.sv
tb/testbench.sv
